FILE: sv/cidat_pkg.sv
// shared types and codes for the card id access table
`timescale 1ns / 1ps

package cidat_pkg;

   // reader modes
   localparam logic [1:0] MODE_DISABLED = 2'd0;
   localparam logic [1:0] MODE_ENABLED  = 2'd1;
   localparam logic [1:0] MODE_LEARN    = 2'd2;
   localparam logic [1:0] MODE_DELETE   = 2'd3;

   // request types
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_ERASE = 1'b1;

   // status codes
   localparam logic [2:0] STAT_NONE       = 3'd0;
   localparam logic [2:0] STAT_GRANTED    = 3'd1;
   localparam logic [2:0] STAT_STORED     = 3'd2;
   localparam logic [2:0] STAT_DELETED    = 3'd3;
   localparam logic [2:0] STAT_ALREADY    = 3'd4;
   localparam logic [2:0] STAT_NOT_LISTED = 3'd5;
   localparam logic [2:0] STAT_FULL       = 3'd6;
   localparam logic [2:0] STAT_INVALID    = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // search token flags handed from cell to cell
   typedef struct packed {
      logic valid;
      logic found;
      logic vacant;
   } token_type;

   // table write command broadcast to all cells
   typedef struct packed {
      logic wr_en;
      logic clr_all;
   } cmd_type;

endpackage

FILE: sv/cidat_cell.sv
// one table slot with its stage of the search chain
`timescale 1ns / 1ps

module cidat_cell
   import cidat_pkg::*;
#(
   parameter int ID_BITS    = 48,
   parameter int IDX_W      = 5,
   parameter int SLOT_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  token_type          prev_tok,
   input  logic [IDX_W-1:0]   prev_found_idx,
   input  logic [IDX_W-1:0]   prev_vacant_idx,
   input  logic [ID_BITS-1:0] query_id,
   input  cmd_type            cmd,
   input  logic [IDX_W-1:0]   cmd_idx,
   input  logic [ID_BITS-1:0] cmd_data,
   output token_type          next_tok,
   output logic [IDX_W-1:0]   next_found_idx,
   output logic [IDX_W-1:0]   next_vacant_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_INDEX);

   logic [ID_BITS-1:0] entry_ff, entry_in;
   token_type          tok_ff, tok_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]   vacant_idx_ff, vacant_idx_in;
   logic               hit, vacant;

   assign hit    = (entry_ff == query_id);
   assign vacant = (entry_ff == {ID_BITS{1'b1}});

   always_comb begin
      tok_in.valid  = prev_tok.valid;
      tok_in.found  = prev_tok.found | hit;
      tok_in.vacant = prev_tok.vacant | vacant;
      found_idx_in  = prev_tok.found ? prev_found_idx : MY_IDX;
      vacant_idx_in = prev_tok.vacant ? prev_vacant_idx : MY_IDX;
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.clr_all) begin
         entry_in = {ID_BITS{1'b1}};
      end else if (cmd.wr_en && (cmd_idx == MY_IDX)) begin
         entry_in = cmd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff  <= {ID_BITS{1'b1}};
         tok_ff    <= '0;
      end else begin
         entry_ff  <= entry_in;
         tok_ff    <= tok_in;
      end
      found_idx_ff  <= found_idx_in;
      vacant_idx_ff <= vacant_idx_in;
   end

   assign next_tok        = tok_ff;
   assign next_found_idx  = found_idx_ff;
   assign next_vacant_idx = vacant_idx_ff;

endmodule

FILE: sv/card_id_access_table.sv
// card id access table top level: control sequencer and chain of slot cells
`timescale 1ns / 1ps

// usage
// - req channel (req_valid / req_stall): one word per card read event or
//   erase-all request; req_stall is high while an item is in work
// - rsp channel (rsp_valid / rsp_stall): exactly one result word per request
// - csr channel (csr_valid / csr_ready): writes reader_mode, always ready;
//   write it only while the block is idle
// flow
// - a card read in modes 1 to 3 with a valid card sends a search token down
//   the chain of TABLE_SLOTS cells, one cell per cycle, through the launch
//   register and each cell register; the tail is captured, and the finish
//   state loads the result word once the output is free
// - erase-all, disabled mode and no-card reads skip the search and go to finish
// - the next request is taken the cycle after the result is loaded, not before
// reset
// - every slot reads empty (all ones), access off, status none, mode 0
// stall
// - a result waiting under rsp_stall stays put; a following item may be
//   accepted and searched, and its result waits until the output is free
module card_id_access_table
   import cidat_pkg::*;
#(
   parameter int TABLE_SLOTS = 20,
   parameter int ID_BITS     = 48
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic               req_card_ok,
   input  logic [ID_BITS-1:0] req_card_id,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status_code,
   output logic               rsp_access_on,
   output logic               rsp_return_to_idle,
   output logic               rsp_backlight_wake,
   output logic               rsp_persist_request,
   // configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_data
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   // control registers
   state_type          state_ff, state_in;
   logic [1:0]         mode_ff;
   logic               launch_ff;
   logic               access_ff, access_in;
   logic [2:0]         status_ff, status_in;

   // latched request word
   logic               erase_ff;
   logic               ok_ff;
   logic [ID_BITS-1:0] id_ff;

   // search results captured from the chain tail
   logic               found_ff;
   logic               vacant_ff;
   logic [IDX_W-1:0]   found_idx_ff;
   logic [IDX_W-1:0]   vacant_idx_ff;

   // output word register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic               rsp_access_ff;
   logic               rsp_idle_ff, rsp_idle_in;
   logic               rsp_wake_ff, rsp_wake_in;
   logic               rsp_persist_ff, rsp_persist_in;

   // fsm decodes
   logic               accept;
   logic               need_scan;
   logic               out_free;
   logic               capture;
   logic               finish;

   // chain wiring
   token_type          tok     [TABLE_SLOTS+1];
   logic [IDX_W-1:0]   fnd_idx [TABLE_SLOTS+1];
   logic [IDX_W-1:0]   vac_idx [TABLE_SLOTS+1];
   cmd_type            cmd;
   logic [IDX_W-1:0]   cmd_idx;
   logic [ID_BITS-1:0] cmd_data;

   assign accept    = req_valid && !req_stall;
   // only live card reads in an active mode need the table searched
   assign need_scan = (req_type == REQ_READ) && req_card_ok && (mode_ff != MODE_DISABLED);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = need_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (tok[TABLE_SLOTS].valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall = 1'b1;
      capture   = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SCAN:   capture   = tok[TABLE_SLOTS].valid;
         ST_FINISH: finish    = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // outcome of the item and the table write it calls for
   always_comb begin
      status_in      = status_ff;
      access_in      = access_ff;
      rsp_idle_in    = 1'b0;
      rsp_wake_in    = 1'b0;
      rsp_persist_in = 1'b0;
      cmd            = '0;
      cmd_idx        = found_idx_ff;
      cmd_data       = {ID_BITS{1'b1}};
      if (erase_ff) begin
         cmd.clr_all    = finish;
         rsp_persist_in = 1'b1;
      end else if (mode_ff != MODE_DISABLED) begin
         if (!ok_ff) begin
            // card taken away: rearm
            status_in = STAT_NONE;
         end else begin
            case (mode_ff)
               MODE_ENABLED: begin
                  rsp_wake_in = 1'b1;
                  if (found_ff) begin
                     // held card acts once
                     if (status_ff == STAT_NONE) begin
                        access_in   = !access_ff;
                        rsp_idle_in = access_ff;
                        status_in   = STAT_GRANTED;
                     end
                  end else begin
                     status_in = STAT_INVALID;
                  end
               end
               MODE_LEARN: begin
                  if (found_ff) begin
                     if (status_ff == STAT_NONE) begin
                        status_in = STAT_ALREADY;
                     end
                  end else if (vacant_ff) begin
                     cmd.wr_en      = finish;
                     cmd_idx        = vacant_idx_ff;
                     cmd_data       = id_ff;
                     rsp_persist_in = 1'b1;
                     status_in      = STAT_STORED;
                  end else if (status_ff == STAT_NONE) begin
                     status_in = STAT_FULL;
                  end
               end
               MODE_DELETE: begin
                  if (found_ff) begin
                     cmd.wr_en = finish;
                     status_in = STAT_DELETED;
                  end else if (status_ff == STAT_NONE) begin
                     status_in = STAT_NOT_LISTED;
                  end
               end
               default: status_in = status_ff;
            endcase
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_DISABLED;
         launch_ff    <= 1'b0;
         access_ff    <= 1'b0;
         status_ff    <= STAT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= accept && need_scan;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         if (finish) begin
            access_ff    <= access_in;
            status_ff    <= status_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         erase_ff <= (req_type == REQ_ERASE);
         ok_ff    <= req_card_ok;
         id_ff    <= req_card_id;
      end
      if (capture) begin
         found_ff      <= tok[TABLE_SLOTS].found;
         vacant_ff     <= tok[TABLE_SLOTS].vacant;
         found_idx_ff  <= fnd_idx[TABLE_SLOTS];
         vacant_idx_ff <= vac_idx[TABLE_SLOTS];
      end
      if (finish) begin
         rsp_status_ff  <= status_in;
         rsp_access_ff  <= access_in;
         rsp_idle_ff    <= rsp_idle_in;
         rsp_wake_ff    <= rsp_wake_in;
         rsp_persist_ff <= rsp_persist_in;
      end
   end

   // token enters the chain head in the cycle after acceptance
   assign tok[0].valid  = launch_ff;
   assign tok[0].found  = 1'b0;
   assign tok[0].vacant = 1'b0;
   assign fnd_idx[0]    = '0;
   assign vac_idx[0]    = '0;

   // chain of slot cells, first match in slot order wins
   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      cidat_cell #(
         .ID_BITS    (ID_BITS),
         .IDX_W      (IDX_W),
         .SLOT_INDEX (i)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .prev_tok        (tok[i]),
         .prev_found_idx  (fnd_idx[i]),
         .prev_vacant_idx (vac_idx[i]),
         .query_id        (id_ff),
         .cmd             (cmd),
         .cmd_idx         (cmd_idx),
         .cmd_data        (cmd_data),
         .next_tok        (tok[i+1]),
         .next_found_idx  (fnd_idx[i+1]),
         .next_vacant_idx (vac_idx[i+1])
      );
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status_code     = rsp_status_ff;
   assign rsp_access_on       = rsp_access_ff;
   assign rsp_return_to_idle  = rsp_idle_ff;
   assign rsp_backlight_wake  = rsp_wake_ff;
   assign rsp_persist_request = rsp_persist_ff;

endmodule

FILE: tb/card_id_access_table_test.sv
// self-checking testbench for the card id access table
`timescale 1ns / 1ps

module card_id_access_table_test;
   import cidat_pkg::*;

   localparam int SLOTS     = 20;
   localparam int ID_W      = 48;
   localparam int POOL_SIZE = 24;      // a few more cards than slots, so learning can fill up
   localparam int PHASE_LEN = 450;     // random words per idling profile
   localparam int LIMIT     = 400000;  // cycle budget, several times the slowest clean run
   localparam int ROWS      = 25;
   localparam logic [ID_W-1:0] EMPTY_ID = '1;

   // one result word, field for field as it leaves the block
   typedef struct packed {
      logic [2:0] status;
      logic       access_on;
      logic       to_idle;
      logic       wake;
      logic       persist;
   } card_result_type;

   // one line of the directed script; pinned lines carry their answer typed in
   typedef struct {
      logic [1:0]      mode;
      logic            rtype;
      logic            ok;
      logic [ID_W-1:0] id;
      logic            pinned;
      logic [2:0]      status;
      logic            access_on;
      logic            to_idle;
      logic            wake;
      logic            persist;
   } script_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic            req_type = REQ_READ;
   logic            req_card_ok = 1'b0;
   logic [ID_W-1:0] req_card_id = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [2:0]      rsp_status_code;
   logic            rsp_access_on;
   logic            rsp_return_to_idle;
   logic            rsp_backlight_wake;
   logic            rsp_persist_request;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_data = MODE_DISABLED;

   // travels with the payload so the monitor sees it at the same edge
   logic            word_pinned = 1'b0;
   card_result_type word_answer = '0;

   // shadow copy of the block's state
   logic [ID_W-1:0] id_shadow [SLOTS];
   logic            access_shadow;
   logic [2:0]      status_shadow;
   logic [1:0]      mode_shadow;

   card_result_type awaited_results [$];
   card_result_type predicted, seen, want;
   logic [ID_W-1:0] id_pool [POOL_SIZE];
   logic [1:0]      mode_now = MODE_DISABLED;
   logic [7:0]      statuses_seen = '0;

   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int cycle_count  = 0;
   int mismatches   = 0;
   int words_in     = 0;
   int erase_words  = 0;
   int words_out    = 0;
   int mode_writes  = 0;

   script_row_type script [ROWS] = '{
      // mode, type, ok, id, pinned, status, access, idle, wake, persist
      // disabled after reset: a read changes nothing
      '{MODE_DISABLED, REQ_READ,  1'b1, 48'h0000_0000_0001, 1'b1, STAT_NONE,    0, 0, 0, 0},
      // erase works in any mode
      '{MODE_DISABLED, REQ_ERASE, 1'b1, 48'h0000_0000_0000, 1'b1, STAT_NONE,    0, 0, 0, 1},
      // enabled, unlisted card
      '{MODE_ENABLED,  REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b1, STAT_INVALID, 0, 0, 1, 0},
      // card taken away clears the status
      '{MODE_ENABLED,  REQ_READ,  1'b0, 48'h0000_0000_0000, 1'b1, STAT_NONE,    0, 0, 0, 0},
      // all-ones id hits an empty slot and counts as listed
      '{MODE_ENABLED,  REQ_READ,  1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_ENABLED,  REQ_READ,  1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 0, 0, 0, 0, 0},
      // learn: store, held card, already stored, extremes
      '{MODE_LEARN,    REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_LEARN,    REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_LEARN,    REQ_READ,  1'b0, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_LEARN,    REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_LEARN,    REQ_READ,  1'b0, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_LEARN,    REQ_READ,  1'b1, 48'hFFFF_FFFF_FFFE, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_LEARN,    REQ_READ,  1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_LEARN,    REQ_READ,  1'b1, 48'h8000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      // enabled: toggle off with idle pulse, held card, toggle on
      '{MODE_ENABLED,  REQ_READ,  1'b0, 48'h5555_5555_5555, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_ENABLED,  REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_ENABLED,  REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_ENABLED,  REQ_READ,  1'b0, 48'hAAAA_AAAA_AAAA, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_ENABLED,  REQ_READ,  1'b1, 48'hFFFF_FFFF_FFFE, 1'b0, 0, 0, 0, 0, 0},
      // delete: remove, held card, not listed, erase keeps status
      '{MODE_DELETE,   REQ_READ,  1'b0, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_DELETE,   REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_DELETE,   REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_DELETE,   REQ_READ,  1'b0, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_DELETE,   REQ_READ,  1'b1, 48'h0000_0000_0000, 1'b0, 0, 0, 0, 0, 0},
      '{MODE_DELETE,   REQ_ERASE, 1'b0, 48'h5555_5555_5555, 1'b0, 0, 0, 0, 0, 0}
   };

   card_id_access_table DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_card_ok         (req_card_ok),
      .req_card_id         (req_card_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status_code     (rsp_status_code),
      .rsp_access_on       (rsp_access_on),
      .rsp_return_to_idle  (rsp_return_to_idle),
      .rsp_backlight_wake  (rsp_backlight_wake),
      .rsp_persist_request (rsp_persist_request),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // first slot holding this id, or -1
   function automatic int slot_of(input logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++) begin
         if (id_shadow[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < SLOTS; i++) id_shadow[i] = EMPTY_ID;
      access_shadow = 1'b0;
      status_shadow = STAT_NONE;
      mode_shadow   = MODE_DISABLED;
   endfunction

   // advance the shadow state by one card word and give the result word it causes
   function automatic card_result_type apply_card_event(input logic rtype, input logic ok,
                                                        input logic [ID_W-1:0] id);
      card_result_type r;
      int hit;
      int hole;
      r = '0;
      if (rtype == REQ_ERASE) begin
         for (int i = 0; i < SLOTS; i++) id_shadow[i] = EMPTY_ID;
         r.persist = 1'b1;
      end else if (mode_shadow != MODE_DISABLED) begin
         if (!ok) begin
            // card taken away
            status_shadow = STAT_NONE;
         end else begin
            hit = slot_of(id);
            case (mode_shadow)
               MODE_ENABLED: begin
                  if (hit >= 0) begin
                     // a held card acts only once
                     if (status_shadow == STAT_NONE) begin
                        r.to_idle     = access_shadow;
                        access_shadow = ~access_shadow;
                        status_shadow = STAT_GRANTED;
                     end
                  end else begin
                     status_shadow = STAT_INVALID;
                  end
                  r.wake = 1'b1;
               end
               MODE_LEARN: begin
                  if (hit >= 0) begin
                     if (status_shadow == STAT_NONE) status_shadow = STAT_ALREADY;
                  end else begin
                     hole = slot_of(EMPTY_ID);
                     if (hole >= 0) begin
                        id_shadow[hole] = id;
                        r.persist       = 1'b1;
                        status_shadow   = STAT_STORED;
                     end else if (status_shadow == STAT_NONE) begin
                        status_shadow = STAT_FULL;
                     end
                  end
               end
               default: begin
                  if (hit >= 0) begin
                     id_shadow[hit] = EMPTY_ID;
                     status_shadow  = STAT_DELETED;
                  end else if (status_shadow == STAT_NONE) begin
                     status_shadow = STAT_NOT_LISTED;
                  end
               end
            endcase
         end
      end
      r.status    = status_shadow;
      r.access_on = access_shadow;
      return r;
   endfunction

   // receiver side: random stall at the current profile
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   // monitor: predict on every accepted word, check every delivered result word
   always @(posedge clock) begin
      if (reset) begin
         clear_shadow();
      end else begin
         if (csr_valid && csr_ready) mode_shadow = csr_data;
         if (req_valid && !req_stall) begin
            predicted = apply_card_event(req_type, req_card_ok, req_card_id);
            awaited_results.push_back(word_pinned ? word_answer : predicted);
            words_in++;
            if (req_type == REQ_ERASE) erase_words++;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_status_code, rsp_access_on, rsp_return_to_idle,
                     rsp_backlight_wake, rsp_persist_request};
            words_out++;
            statuses_seen[rsp_status_code] = 1'b1;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with nothing awaited: status %0d access %b",
                           $realtime, seen.status, seen.access_on);
            end else begin
               want = awaited_results.pop_front();
               if (seen.status !== want.status || seen.access_on !== want.access_on ||
                   seen.to_idle !== want.to_idle || seen.wake !== want.wake ||
                   seen.persist !== want.persist) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result word %0d: expected status %0d access %b idle %b wake %b persist %b",
                              $realtime, words_out, want.status, want.access_on,
                              want.to_idle, want.wake, want.persist);
                     $display("   got status %0d access %b idle %b wake %b persist %b",
                              seen.status, seen.access_on, seen.to_idle, seen.wake,
                              seen.persist);
                  end
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("cycle limit hit with %0d result words still awaited",
                  awaited_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // present one word; valid stays high from the previous word unless a gap is taken
   task automatic send_word(input logic rtype, input logic ok, input logic [ID_W-1:0] id,
                            input logic pinned, input card_result_type answer);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_valid   <= 1'b1;
      req_type    <= rtype;
      req_card_ok <= ok;
      req_card_id <= id;
      word_pinned <= pinned;
      word_answer <= answer;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mode changes only once the block has drained
   task automatic write_mode(input logic [1:0] mode);
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mode_now = mode;
      mode_writes++;
   endtask

   // random part: runs of one mode with a small card pool, repeats and removals
   task automatic run_random(input int count);
      int left;
      int seg;
      int pick;
      logic [1:0]      mode;
      logic            rtype;
      logic            ok;
      logic [63:0]     wide;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] last_id;
      left    = count;
      last_id = id_pool[0];
      while (left > 0) begin
         pick = $urandom_range(9);
         mode = (pick < 4) ? MODE_LEARN : (pick < 7) ? MODE_ENABLED :
                (pick < 9) ? MODE_DELETE : MODE_DISABLED;
         write_mode(mode);
         seg = $urandom_range(50, 10);
         if (seg > left) seg = left;
         repeat (seg) begin
            rtype = ($urandom_range(99) < 2) ? REQ_ERASE : REQ_READ;
            ok    = ($urandom_range(99) < 65);
            pick  = $urandom_range(99);
            wide  = {$urandom, $urandom};
            if (pick < 30)      id = last_id;   // card still held at the reader
            else if (pick < 85) id = id_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 90) id = EMPTY_ID;
            else                id = wide[ID_W-1:0];
            last_id = id;
            send_word(rtype, ok, id, 1'b0, '0);
            left--;
         end
      end
   endtask

   initial begin
      card_result_type answer;
      logic [63:0]     wide;
      for (int i = 0; i < POOL_SIZE; i++) begin
         wide       = {$urandom, $urandom};
         id_pool[i] = wide[ID_W-1:0];
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script under the first idling profile
      snd_idle_pct = 7;
      rcv_idle_pct = 57;
      for (int k = 0; k < ROWS; k++) begin
         if (script[k].mode != mode_now) write_mode(script[k].mode);
         answer = '{script[k].status, script[k].access_on, script[k].to_idle,
                    script[k].wake, script[k].persist};
         send_word(script[k].rtype, script[k].ok, script[k].id, script[k].pinned, answer);
      end

      run_random(PHASE_LEN);
      snd_idle_pct = 57;
      rcv_idle_pct = 7;
      run_random(PHASE_LEN);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      run_random(PHASE_LEN);

      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
      repeat (40) @(posedge clock);

      $display("ran %0d card words (%0d erase-all) under %0d mode writes and three stall mixes",
               words_in, erase_words, mode_writes);
      $display("checked %0d result words, status codes observed %b", words_out, statuses_seen);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
